// ===== rtl/bqcomb_pkg.sv =====
package bqcomb_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 24;
	localparam int COEF_FRAC   = COEF_BITS - 4;
	localparam int STATE_BITS  = SAMPLE_BITS + COEF_BITS;
	localparam int PROD_W      = COEF_BITS + 1 + SAMPLE_BITS;
	localparam int ACC_W       = STATE_BITS + 3;

	localparam int RING_DEPTH  = 1024;
	localparam int RING_AW     = $clog2(RING_DEPTH);

	localparam int DELAY_BITS  = 10;
	localparam int GAIN_BITS   = 16;
	localparam int GAIN_FRAC   = 16;
	localparam logic [GAIN_BITS-1:0] GAIN_LIMIT = GAIN_BITS'(62259);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic signed [COEF_BITS-1:0]  COEF_ONE    = COEF_BITS'(1) << COEF_FRAC;
	localparam logic [DELAY_BITS-1:0]        DELAY_RESET = DELAY_BITS'(100);

	localparam logic signed [ACC_W-1:0] COEF_HALF = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] GAIN_HALF = ACC_W'(1) << (GAIN_FRAC - 1);

	localparam logic signed [ACC_W-1:0] SAMPLE_MAX =
		{{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;
	localparam logic signed [ACC_W-1:0] STATE_MAX =
		{{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] STATE_MIN = ~STATE_MAX;

	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_B0    = 3'd1,
		REG_B1    = 3'd2,
		REG_B2    = 3'd3,
		REG_A1    = 3'd4,
		REG_A2    = 3'd5,
		REG_DELAY = 3'd6,
		REG_GAIN  = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_B_B0,
		S_B_B1,
		S_B_A1,
		S_B_B2,
		S_B_A2,
		S_B_FIN,
		S_C_RD,
		S_C_MUL,
		S_C_FIN,
		S_OUT
	} seq_state_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v > SAMPLE_MAX) begin
			r = SAMPLE_MAX[SAMPLE_BITS-1:0];
		end else if (v < SAMPLE_MIN) begin
			r = SAMPLE_MIN[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [ACC_W-1:0] v);
		logic signed [STATE_BITS-1:0] r;
		if (v > STATE_MAX) begin
			r = STATE_MAX[STATE_BITS-1:0];
		end else if (v < STATE_MIN) begin
			r = STATE_MIN[STATE_BITS-1:0];
		end else begin
			r = v[STATE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/bqcomb_ram.sv =====
module bqcomb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/biquad_and_feedback_comb_filter_core.sv =====
// channel  | handshake                         | payload
// input    | sample_in_valid / sample_in_stall   | sample_in
// output   | sample_out_valid / sample_out_stall | sample_out
// config   | psel / penable / pwrite / pready    | paddr, pwdata, prdata
//
// Biquad: five products go one at a time through a single 25x16 multiplier;
// each is registered and then combined with the filter state in the next state.
// Comb: each transaction takes a ring read, a gain product, then a round and store.
// Reset needs no ring sweep: the write pointer and a wrap flag mark which ring
// entries were written; older entries read as zero.
// The result sits in an output register; a new transaction is accepted as soon
// as the result has moved there, even while sample_out_stall holds it.
module biquad_and_feedback_comb_filter_core (
	input  logic                                        clk,
	input  logic                                        arst_n,

	input  logic                                        sample_in_valid,
	output logic                                        sample_in_stall,
	input  logic signed [bqcomb_pkg::SAMPLE_BITS-1:0]   sample_in,

	output logic                                        sample_out_valid,
	input  logic                                        sample_out_stall,
	output logic signed [bqcomb_pkg::SAMPLE_BITS-1:0]   sample_out,

	input  logic                                        psel,
	input  logic                                        penable,
	input  logic                                        pwrite,
	input  logic [bqcomb_pkg::ADDR_W-1:0]               paddr,
	input  logic [bqcomb_pkg::DATA_W-1:0]               pwdata,
	output logic [bqcomb_pkg::DATA_W-1:0]               prdata,
	output logic                                        pready
);

	localparam int SB = bqcomb_pkg::SAMPLE_BITS;
	localparam int CB = bqcomb_pkg::COEF_BITS;
	localparam int AW = bqcomb_pkg::RING_AW;
	localparam int DB = bqcomb_pkg::DELAY_BITS;
	localparam int GB = bqcomb_pkg::GAIN_BITS;
	localparam int XW = bqcomb_pkg::ACC_W;
	localparam int PW = bqcomb_pkg::PROD_W;
	localparam int TW = bqcomb_pkg::STATE_BITS;
	localparam int DW = bqcomb_pkg::DATA_W;

	// configuration
	logic                 mode_q;
	logic signed [CB-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [DB-1:0]        delay_q;
	logic [GB-1:0]        gain_q;

	bqcomb_pkg::cfg_reg_t reg_sel;
	logic                 cfg_wr;

	// sequencer and datapath
	bqcomb_pkg::seq_state_t state_q, state_d;

	logic signed [SB-1:0] x_q;
	logic signed [SB-1:0] y_q;
	logic signed [PW-1:0] p_q;
	logic signed [XW-1:0] acc_q;
	logic signed [TW-1:0] s1_q, s2_q;
	logic [AW-1:0]        wr_ptr_q;
	logic                 wrapped_q;
	logic                 rvalid_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] out_data_q;

	logic signed [CB:0]   mul_a;
	logic signed [SB-1:0] mul_b;
	logic                 accept;
	logic                 out_load;
	logic [DB-1:0]        delay_eff;
	logic [GB-1:0]        gain_eff;
	logic [AW-1:0]        rd_addr;
	logic                 ram_re;
	logic                 ram_we;
	logic [SB-1:0]        ram_rdata;
	logic signed [XW-1:0] bq_sum;
	logic signed [XW-1:0] bq_rnd;
	logic signed [SB-1:0] bq_y;
	logic signed [XW-1:0] cb_sum;
	logic signed [XW-1:0] cb_rnd;
	logic signed [SB-1:0] cb_y;

	// APB
	assign pready  = 1'b1;
	assign reg_sel = bqcomb_pkg::cfg_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_sel)
			bqcomb_pkg::REG_MODE:  prdata = DW'(mode_q);
			bqcomb_pkg::REG_B0:    prdata = DW'(b0_q);
			bqcomb_pkg::REG_B1:    prdata = DW'(b1_q);
			bqcomb_pkg::REG_B2:    prdata = DW'(b2_q);
			bqcomb_pkg::REG_A1:    prdata = DW'(a1_q);
			bqcomb_pkg::REG_A2:    prdata = DW'(a2_q);
			bqcomb_pkg::REG_DELAY: prdata = DW'(delay_q);
			bqcomb_pkg::REG_GAIN:  prdata = DW'(gain_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			b0_q    <= bqcomb_pkg::COEF_ONE;
			b1_q    <= '0;
			b2_q    <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
			delay_q <= bqcomb_pkg::DELAY_RESET;
			gain_q  <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				bqcomb_pkg::REG_MODE:  mode_q  <= pwdata[0];
				bqcomb_pkg::REG_B0:    b0_q    <= pwdata[CB-1:0];
				bqcomb_pkg::REG_B1:    b1_q    <= pwdata[CB-1:0];
				bqcomb_pkg::REG_B2:    b2_q    <= pwdata[CB-1:0];
				bqcomb_pkg::REG_A1:    a1_q    <= pwdata[CB-1:0];
				bqcomb_pkg::REG_A2:    a2_q    <= pwdata[CB-1:0];
				bqcomb_pkg::REG_DELAY: delay_q <= pwdata[DB-1:0];
				bqcomb_pkg::REG_GAIN:  gain_q  <= pwdata[GB-1:0];
			endcase
		end
	end

	// handshakes
	assign sample_in_stall  = (state_q != bqcomb_pkg::S_IDLE);
	assign accept           = sample_in_valid && !sample_in_stall;
	assign out_load         = (state_q == bqcomb_pkg::S_OUT) &&
	                          (!out_valid_q || !sample_out_stall);
	assign sample_out_valid = out_valid_q;
	assign sample_out       = out_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bqcomb_pkg::S_IDLE: begin
				if (accept) begin
					state_d = mode_q ? bqcomb_pkg::S_C_RD : bqcomb_pkg::S_B_B0;
				end
			end
			bqcomb_pkg::S_B_B0:  state_d = bqcomb_pkg::S_B_B1;
			bqcomb_pkg::S_B_B1:  state_d = bqcomb_pkg::S_B_A1;
			bqcomb_pkg::S_B_A1:  state_d = bqcomb_pkg::S_B_B2;
			bqcomb_pkg::S_B_B2:  state_d = bqcomb_pkg::S_B_A2;
			bqcomb_pkg::S_B_A2:  state_d = bqcomb_pkg::S_B_FIN;
			bqcomb_pkg::S_B_FIN: state_d = bqcomb_pkg::S_OUT;
			bqcomb_pkg::S_C_RD:  state_d = bqcomb_pkg::S_C_MUL;
			bqcomb_pkg::S_C_MUL: state_d = bqcomb_pkg::S_C_FIN;
			bqcomb_pkg::S_C_FIN: state_d = bqcomb_pkg::S_OUT;
			bqcomb_pkg::S_OUT: begin
				if (out_load) begin
					state_d = bqcomb_pkg::S_IDLE;
				end
			end
			default: state_d = bqcomb_pkg::S_IDLE;
		endcase
	end

	// multiplier operands and memory strobes
	assign gain_eff  = (gain_q > bqcomb_pkg::GAIN_LIMIT) ? bqcomb_pkg::GAIN_LIMIT : gain_q;
	assign delay_eff = (delay_q == '0) ? DB'(1) : delay_q;
	assign rd_addr   = wr_ptr_q - AW'(delay_eff);

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		ram_re = 1'b0;
		ram_we = 1'b0;
		unique case (state_q)
			bqcomb_pkg::S_B_B0: begin
				mul_a = (CB+1)'(b0_q);
				mul_b = x_q;
			end
			bqcomb_pkg::S_B_B1: begin
				mul_a = (CB+1)'(b1_q);
				mul_b = x_q;
			end
			bqcomb_pkg::S_B_A1: begin
				mul_a = (CB+1)'(a1_q);
				mul_b = y_q;
			end
			bqcomb_pkg::S_B_B2: begin
				mul_a = (CB+1)'(b2_q);
				mul_b = x_q;
			end
			bqcomb_pkg::S_B_A2: begin
				mul_a = (CB+1)'(a2_q);
				mul_b = y_q;
			end
			bqcomb_pkg::S_C_RD: begin
				ram_re = 1'b1;
			end
			bqcomb_pkg::S_C_MUL: begin
				mul_a = (CB+1)'(signed'({1'b0, gain_eff}));
				mul_b = rvalid_q ? signed'(ram_rdata) : '0;
			end
			bqcomb_pkg::S_C_FIN: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// rounding and saturation
	assign bq_sum = XW'(p_q) + XW'(s1_q);
	assign bq_rnd = (bq_sum + bqcomb_pkg::COEF_HALF) >>> bqcomb_pkg::COEF_FRAC;
	assign bq_y   = bqcomb_pkg::sat_sample(bq_rnd);

	assign cb_sum = (XW'(x_q) <<< bqcomb_pkg::GAIN_FRAC) + XW'(p_q);
	assign cb_rnd = (cb_sum + bqcomb_pkg::GAIN_HALF) >>> bqcomb_pkg::GAIN_FRAC;
	assign cb_y   = bqcomb_pkg::sat_sample(cb_rnd);

	bqcomb_ram #(
		.WIDTH(SB),
		.DEPTH(bqcomb_pkg::RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q),
		.wdata(cb_y),
		.re   (ram_re),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bqcomb_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			wr_ptr_q    <= '0;
			wrapped_q   <= 1'b0;
			s1_q        <= '0;
			s2_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!sample_out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == bqcomb_pkg::S_B_B2) begin
				s1_q <= bqcomb_pkg::sat_state(acc_q - XW'(p_q));
			end
			if (state_q == bqcomb_pkg::S_B_FIN) begin
				s2_q <= bqcomb_pkg::sat_state(acc_q - XW'(p_q));
			end
			if (state_q == bqcomb_pkg::S_C_FIN) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
				if (wr_ptr_q == '1) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		p_q <= PW'(mul_a) * PW'(mul_b);
		if (accept) begin
			x_q <= sample_in;
		end
		unique case (state_q)
			bqcomb_pkg::S_B_B1:  y_q   <= bq_y;
			bqcomb_pkg::S_B_A1:  acc_q <= XW'(p_q) + XW'(s2_q);
			bqcomb_pkg::S_B_A2:  acc_q <= XW'(p_q);
			bqcomb_pkg::S_C_RD:  rvalid_q <= wrapped_q || (rd_addr < wr_ptr_q);
			bqcomb_pkg::S_C_FIN: y_q   <= cb_y;
			default: begin
			end
		endcase
		if (out_load) begin
			out_data_q <= y_q;
		end
	end

	// checks
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bqcomb_pkg::S_OUT))
		else $error("output valid rose outside the output step");

	a_ptr_on_comb: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wr_ptr_q) |-> $past(state_q == bqcomb_pkg::S_C_FIN))
		else $error("ring pointer moved outside a comb store");

	a_s1_on_biquad: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(s1_q) |-> $past(state_q == bqcomb_pkg::S_B_B2))
		else $error("biquad state one changed outside its update");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("ring wrap flag cleared");

endmodule

// ===== tb/sv/bqcomb_tb_pkg.sv =====
`timescale 1ns / 1ps

package bqcomb_tb_pkg;

	import bqcomb_pkg::*;

	class filter_scoreboard;

		bit                            comb_mode;
		logic signed [COEF_BITS-1:0]   coef [5];    // b0 b1 b2 a1 a2
		logic [DELAY_BITS-1:0]         delay;
		logic [GAIN_BITS-1:0]          gain;
		logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
		logic [RING_AW-1:0]            wr_ptr;
		longint                        s1;
		longint                        s2;
		logic signed [SAMPLE_BITS-1:0] expected_samples [$];
		int                            errors;

		function new();
			comb_mode = 1'b0;
			coef[0] = COEF_ONE;
			for (int k = 1; k < 5; k++) begin
				coef[k] = '0;
			end
			delay = DELAY_RESET;
			gain = '0;
			for (int k = 0; k < RING_DEPTH; k++) begin
				ring[k] = '0;
			end
			wr_ptr = '0;
			s1 = 0;
			s2 = 0;
			errors = 0;
		endfunction

		function void set_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
			case (r)
				REG_MODE: begin
					comb_mode = v[0];
				end
				REG_B0: begin
					coef[0] = v[COEF_BITS-1:0];
				end
				REG_B1: begin
					coef[1] = v[COEF_BITS-1:0];
				end
				REG_B2: begin
					coef[2] = v[COEF_BITS-1:0];
				end
				REG_A1: begin
					coef[3] = v[COEF_BITS-1:0];
				end
				REG_A2: begin
					coef[4] = v[COEF_BITS-1:0];
				end
				REG_DELAY: begin
					delay = v[DELAY_BITS-1:0];
				end
				REG_GAIN: begin
					gain = v[GAIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint clamp(input longint v, input int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) << (bits - 1)) - 1;
			lo = -hi - 1;
			return (v > hi) ? hi : ((v < lo) ? lo : v);
		endfunction

		// floor((v + half lsb) / 2^sh)
		function longint round_half_up(input longint v, input int sh);
			return (v + (longint'(1) << (sh - 1))) >>> sh;
		endfunction

		function logic signed [SAMPLE_BITS-1:0] filter_sample(
			input logic signed [SAMPLE_BITS-1:0] x);
			longint             xv;
			longint             yv;
			longint             acc;
			longint             g;
			logic [RING_AW-1:0] d;
			logic [RING_AW-1:0] rd;
			xv = longint'(x);
			if (!comb_mode) begin
				acc = longint'(coef[0]) * xv + s1;
				yv = clamp(round_half_up(acc, COEF_FRAC), SAMPLE_BITS);
				s1 = clamp(longint'(coef[1]) * xv - longint'(coef[3]) * yv + s2, STATE_BITS);
				s2 = clamp(longint'(coef[2]) * xv - longint'(coef[4]) * yv, STATE_BITS);
			end else begin
				d = (delay == 0) ? RING_AW'(1) : RING_AW'(delay);
				rd = wr_ptr - d;
				g = longint'((gain > GAIN_LIMIT) ? GAIN_LIMIT : gain);
				acc = xv * (longint'(1) << GAIN_FRAC) + g * longint'(ring[rd]);
				yv = clamp(round_half_up(acc, GAIN_FRAC), SAMPLE_BITS);
				ring[wr_ptr] = yv[SAMPLE_BITS-1:0];
				wr_ptr = wr_ptr + 1'b1;
			end
			return yv[SAMPLE_BITS-1:0];
		endfunction

		function void accept_sample(input logic signed [SAMPLE_BITS-1:0] x);
			expected_samples.push_back(filter_sample(x));
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		task report_mismatch(input string what);
			if (errors < 200) begin
				$display("[%0t] mismatch: %s", $time, what);
			end
			errors++;
		endtask

		task check_sample_out(input logic signed [SAMPLE_BITS-1:0] got);
			logic signed [SAMPLE_BITS-1:0] want;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample_out %0d", got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("sample_out %0d, expected %0d", got, want));
				end
			end
		endtask

	endclass

endpackage

// ===== tb/sv/biquad_and_feedback_comb_filter_core_tb.sv =====
`timescale 1ns / 1ps

module biquad_and_feedback_comb_filter_core_tb;

	import bqcomb_pkg::*;
	import bqcomb_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 40;
	localparam int ITEM_TARGET    = 1750;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_BITS'(32767);
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_BITS'(-32768);
	localparam logic signed [COEF_BITS-1:0]   C_MAX = COEF_BITS'(8388607);
	localparam logic signed [COEF_BITS-1:0]   C_MIN = COEF_BITS'(-8388608);

	// mild low-pass section, b0 b1 b2 a1 a2
	localparam int STABLE_COEF [5] = '{70779, 141558, 70779, -1198418, 432852};
	localparam cfg_reg_t COEF_REGS [5] = '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};

	logic                          clk;
	logic                          arst_n;
	logic                          sample_in_valid;
	logic                          sample_in_stall;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          sample_out_valid;
	logic                          sample_out_stall;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ADDR_W-1:0]             paddr;
	logic [DATA_W-1:0]             pwdata;
	logic [DATA_W-1:0]             prdata;
	logic                          pready;

	filter_scoreboard sb;
	bit               quiet;
	bit               hold_req;

	biquad_and_feedback_comb_filter_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_in_valid  (sample_in_valid),
		.sample_in_stall  (sample_in_stall),
		.sample_in        (sample_in),
		.sample_out_valid (sample_out_valid),
		.sample_out_stall (sample_out_stall),
		.sample_out       (sample_out),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return S_MAX;
		end else if (r == 1) begin
			return S_MIN;
		end else if (r == 2) begin
			return SAMPLE_BITS'(int'($urandom_range(0, 255)) - 128);
		end
		return SAMPLE_BITS'($urandom());
	endfunction

	function automatic logic signed [COEF_BITS-1:0] pick_coef(input int k);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return C_MAX;
		end else if (r == 1) begin
			return C_MIN;
		end else if (r < 6) begin
			return COEF_BITS'(STABLE_COEF[k] + int'($urandom_range(0, 4000)) - 2000);
		end
		return COEF_BITS'($urandom());
	endfunction

	function automatic logic [DATA_W-1:0] coef_word(input logic signed [COEF_BITS-1:0] c);
		return DATA_W'(c);
	endfunction

	function automatic logic [DATA_W-1:0] pick_delay();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 0;
		end else if (r == 1) begin
			return (1 << DELAY_BITS) - 1;
		end else if (r < 7) begin
			return $urandom_range(1, 16);
		end
		return $urandom_range(1, (1 << DELAY_BITS) - 1);
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 0;
		end else if (r == 1) begin
			return DATA_W'(GAIN_LIMIT);
		end else if (r == 2) begin
			return $urandom_range(int'(GAIN_LIMIT) + 1, (1 << GAIN_BITS) - 1);
		end
		return $urandom_range(0, int'(GAIN_LIMIT));
	endfunction

	task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(r) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(r, v);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit last);
		int gap;
		sample_in <= x;
		sample_in_valid <= 1'b1;
		do @(posedge clk); while (sample_in_stall);
		sb.accept_sample(x);
		gap = quiet ? 0 : pick_gap();
		if (last || gap > 0) begin
			sample_in_valid <= 1'b0;
		end
		if (!last) begin
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic randomize_config();
		write_reg(REG_MODE, DATA_W'($urandom_range(0, 2) != 0));
		for (int k = 0; k < 5; k++) begin
			if ($urandom_range(0, 3) != 0) begin
				write_reg(COEF_REGS[k], coef_word(pick_coef(k)));
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(REG_DELAY, pick_delay());
		end
		if ($urandom_range(0, 3) != 0) begin
			write_reg(REG_GAIN, pick_gain());
		end
	endtask

	task automatic run_phase(input int count);
		for (int i = 0; i < count; i++) begin
			send_sample(pick_sample(), i == count - 1);
		end
		wait_drained();
	endtask

	// receiver: checks each transaction, random stalls, one long hold-off on request
	initial begin
		int  stall_left;
		int  hold_left;
		bit  stall_next;
		stall_left = 0;
		hold_left = 0;
		sample_out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && sample_out_valid && !sample_out_stall) begin
				sb.check_sample_out(sample_out);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (quiet) begin
				stall_next = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else begin
				stall_left = pick_gap();
				stall_next = 1'b0;
			end
			sample_out_stall <= stall_next;
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_in_valid && !sample_in_stall) ||
				(sample_out_valid && !sample_out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int total;
		int n;
		bit pressed;
		arst_n = 1'b0;
		sample_in_valid = 1'b0;
		sample_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		pressed = 1'b0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: unity biquad
		send_sample(SAMPLE_BITS'(0), 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(SAMPLE_BITS'(1), 1'b0);
		send_sample(SAMPLE_BITS'(-1), 1'b1);
		wait_drained();

		// coefficient extremes, output and state saturate
		write_reg(REG_B0, coef_word(C_MAX));
		write_reg(REG_B1, coef_word(C_MIN));
		write_reg(REG_B2, coef_word(C_MAX));
		write_reg(REG_A1, coef_word(C_MIN));
		write_reg(REG_A2, coef_word(C_MAX));
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(SAMPLE_BITS'(12345), 1'b1);
		wait_drained();

		// comb with zero delay and gain above the clamp
		write_reg(REG_MODE, 1);
		write_reg(REG_DELAY, 0);
		write_reg(REG_GAIN, (1 << GAIN_BITS) - 1);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(SAMPLE_BITS'(0), 1'b1);
		wait_drained();

		// longest delay, gain at the clamp
		write_reg(REG_DELAY, (1 << DELAY_BITS) - 1);
		write_reg(REG_GAIN, DATA_W'(GAIN_LIMIT));
		send_sample(S_MIN, 1'b0);
		send_sample(SAMPLE_BITS'(100), 1'b0);
		send_sample(S_MAX, 1'b1);
		wait_drained();

		// back to biquad, state kept across the mode change
		write_reg(REG_MODE, 0);
		send_sample(SAMPLE_BITS'(1000), 1'b0);
		send_sample(SAMPLE_BITS'(-1000), 1'b0);
		send_sample(S_MAX, 1'b1);
		wait_drained();

		total = 0;
		while (total < ITEM_TARGET) begin
			n = $urandom_range(30, 120);
			randomize_config();
			quiet = ($urandom_range(0, 4) == 0);
			if (total > 200 && !pressed) begin
				pressed = 1'b1;
				quiet = 1'b0;
				hold_req = 1'b1;
			end
			run_phase(n);
			total += n;
		end
		quiet = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bqcomb_pkg.sv
rtl/bqcomb_ram.sv
rtl/biquad_and_feedback_comb_filter_core.sv
tb/sv/bqcomb_tb_pkg.sv
tb/sv/biquad_and_feedback_comb_filter_core_tb.sv
